// ----- rtl/bole_pkg.sv -----
// Shared types, codes and sizes for the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  // Default sizes of the list.
  localparam int LIST_CAPACITY   = 16;
  localparam int LIST_DATA_WIDTH = 32;

  // Fixed field widths of the stream items.
  localparam int LIST_CMD_W     = 3;
  localparam int LIST_POS_W     = 5;
  localparam int LIST_VAL_W     = 32;
  localparam int LIST_CNT_OUT_W = 5;
  localparam int LIST_STATUS_W  = 2;

  // Width used for all index and count compares; covers the largest capacity.
  localparam int LIST_CNT_W = 11;

  // Stream widths: input item and result item, padded to whole bytes.
  localparam int LIST_IN_W  = 40;
  localparam int LIST_OUT_W = 104;

  // Command codes.
  typedef enum logic [LIST_CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_PREPEND    = 3'd1,
    CMD_TAKE_FIRST = 3'd2,
    CMD_TAKE_LAST  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6
  } cmd_e;

  // Result status codes.
  typedef enum logic [LIST_STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                  open_gap;   // shift toward the back from at_idx on
    logic                  close_gap;  // shift toward the front onto at_idx
    logic [LIST_CNT_W-1:0] at_idx;     // position of the gap
    logic [LIST_CNT_W-1:0] cnt;        // element count before the operation
    logic [LIST_VAL_W-1:0] value;      // data to place into the new gap
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: decode, cell chain and result register.
`default_nettype none

// The list lives in a chain of Capacity cells, one element each, with the
// front at cell 0. Every command item is decoded in the cycle it is accepted
// and all cells shift toward the back, shift toward the front or hold in that
// same cycle, so the engine takes one item per clock while the master side is
// not stalled, and its result item appears on the master side in the cycle after
// acceptance. The result sits in an output register; the slave side stays ready
// while that register is empty or being drained, so a stalled master side holds
// back the next item. Pops, erases and reads on an empty list or at a bad
// position leave the list as it is and report that in the status field.
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int Capacity  = LIST_CAPACITY,
  parameter int DataWidth = LIST_DATA_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cmd [2:0], position [7:3], value [39:8]
  input  wire logic [LIST_IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // count [4:0], front_value [36:5], back_value [68:37], read_value [100:69],
  // status [102:101], zero [103]
  output logic      [LIST_OUT_W-1:0] m_axis_tdata
);

  localparam int CntW   = $clog2(Capacity + 1);
  localparam int StoreW = (DataWidth < LIST_VAL_W) ? DataWidth : LIST_VAL_W;
  localparam logic [LIST_CNT_W-1:0] CapCnt = LIST_CNT_W'(Capacity);

  // Input item fields.
  logic [LIST_CMD_W-1:0] cmd;
  logic [LIST_POS_W-1:0] position;
  logic [LIST_VAL_W-1:0] value;

  assign cmd      = s_axis_tdata[LIST_CMD_W-1:0];
  assign position = s_axis_tdata[LIST_CMD_W+LIST_POS_W-1:LIST_CMD_W];
  assign value    = s_axis_tdata[LIST_CMD_W+LIST_POS_W+LIST_VAL_W-1:LIST_CMD_W+LIST_POS_W];

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [LIST_OUT_W-1:0] out_data_q;
  logic                  accept;

  logic [LIST_CNT_W-1:0] cnt_ext, pos_ext, cnt_next_ext;
  logic                  full, empty;
  status_e               status;
  logic                  do_open, do_close, do_dec, do_inc, do_read;
  logic [LIST_CNT_W-1:0] at_idx;
  cell_ctrl_t            ctrl;

  logic [StoreW-1:0] elem_q [Capacity];
  logic [StoreW-1:0] elem_d [Capacity];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cnt_ext = LIST_CNT_W'(count_q);
  assign pos_ext = LIST_CNT_W'(position);
  assign full    = (cnt_ext >= CapCnt);
  assign empty   = (count_q == '0);

  // Command decode: choose the shift, the gap position and the status.
  always_comb begin
    status   = ST_OK;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_dec   = 1'b0;
    do_read  = 1'b0;
    at_idx   = '0;
    unique case (cmd)
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_open = 1'b1;
          at_idx  = cnt_ext;
        end
      end
      CMD_PREPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_open = 1'b1;
        end
      end
      CMD_TAKE_FIRST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_close = 1'b1;
        end
      end
      CMD_TAKE_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_dec = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_BADPOS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          do_open = 1'b1;
          at_idx  = pos_ext;
        end
      end
      CMD_ERASE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = ST_BADPOS;
        end else begin
          do_close = 1'b1;
          at_idx   = pos_ext;
        end
      end
      CMD_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BADPOS;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign do_inc = do_open;

  // Broadcast to the chain; nothing moves unless an item is accepted.
  always_comb begin
    ctrl.open_gap  = accept && do_open;
    ctrl.close_gap = accept && do_close;
    ctrl.at_idx    = at_idx;
    ctrl.cnt       = cnt_ext;
    ctrl.value     = value;
  end

  // Count after the operation.
  always_comb begin
    count_d = count_q;
    if (do_inc) begin
      count_d = count_q + CntW'(1);
    end else if (do_close || do_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign cnt_next_ext = LIST_CNT_W'(count_d);

  // Chain of cells; the ends see zero beyond them.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [StoreW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = elem_q[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = elem_q[i+1];
    end
    bole_cell #(
      .Idx (i),
      .W   (StoreW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .right_i     (right),
      .elem_o      (elem_q[i]),
      .elem_next_o (elem_d[i])
    );
  end

  // Result fields: each cell contributes when its place matches.
  logic [LIST_VAL_W-1:0] front_val, back_val, read_val;
  always_comb begin
    front_val = '0;
    back_val  = '0;
    read_val  = '0;
    if (count_d != '0) begin
      front_val[StoreW-1:0] = elem_d[0];
    end
    for (int i = 0; i < Capacity; i++) begin
      if (LIST_CNT_W'(i + 1) == cnt_next_ext) begin
        back_val[StoreW-1:0] = back_val[StoreW-1:0] | elem_d[i];
      end
      if (do_read && LIST_CNT_W'(i) == pos_ext) begin
        read_val[StoreW-1:0] = read_val[StoreW-1:0] | elem_q[i];
      end
    end
  end

  // Count register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, status, read_val, back_val, front_val,
                     cnt_next_ext[LIST_CNT_OUT_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/bole_cell.sv -----
// One storage cell of the list chain: holds, loads, or takes a neighbor's element.
`default_nettype none

module bole_cell
  import bole_pkg::*;
#(
  parameter int Idx = 0,
  parameter int W   = LIST_DATA_WIDTH
) (
  input  wire logic         clk_i,
  input  wire cell_ctrl_t   ctrl_i,
  input  wire logic [W-1:0] left_i,   // element of the cell one place nearer the front
  input  wire logic [W-1:0] right_i,  // element of the cell one place nearer the back
  output logic      [W-1:0] elem_o,
  output logic      [W-1:0] elem_next_o
);

  localparam logic [LIST_CNT_W-1:0] MyIdx  = LIST_CNT_W'(Idx);
  localparam logic [LIST_CNT_W-1:0] NextIx = LIST_CNT_W'(Idx + 1);

  logic [W-1:0] elem_q, elem_d;

  // Select the next element from the broadcast operation and this cell's place.
  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.open_gap) begin
      if (MyIdx == ctrl_i.at_idx) begin
        elem_d = ctrl_i.value[W-1:0];
      end else if (MyIdx > ctrl_i.at_idx && MyIdx <= ctrl_i.cnt) begin
        elem_d = left_i;
      end
    end else if (ctrl_i.close_gap) begin
      if (MyIdx >= ctrl_i.at_idx && NextIx < ctrl_i.cnt) begin
        elem_d = right_i;
      end
    end
  end

  // Element payload needs no reset: only places below the count are ever read.
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o      = elem_q;
  assign elem_next_o = elem_d;

endmodule

`default_nettype wire

// ----- rtl/bole_checker.sv -----
// Port-level checks for the bounded ordered list engine and their binding.
`default_nettype none

module bole_checker
  import bole_pkg::*;
#(
  parameter int Capacity = LIST_CAPACITY
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [LIST_OUT_W-1:0] m_axis_tdata
);

  logic [LIST_CNT_OUT_W-1:0] r_count;
  logic [LIST_VAL_W-1:0]     r_front, r_back;
  logic [LIST_STATUS_W-1:0]  r_status;

  assign r_count  = m_axis_tdata[4:0];
  assign r_front  = m_axis_tdata[36:5];
  assign r_back   = m_axis_tdata[68:37];
  assign r_status = m_axis_tdata[102:101];

  // A held result blocks the next item.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  // Every accepted item yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after an accepted item");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (Capacity > 31 || int'(r_count) <= Capacity))
    else $error("count above capacity");

  // An empty list shows zero at both ends.
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && r_count == '0 && Capacity < 32) |-> (r_front == '0 && r_back == '0))
    else $error("empty list shows nonzero ends");

  // An ignored pop only happens on an empty list.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && r_status == ST_EMPTY && Capacity < 32) |-> (r_count == '0))
    else $error("empty status on a nonempty list");

endmodule

bind bounded_ordered_list_engine bole_checker #(.Capacity(Capacity)) u_bole_checker (.*);

`default_nettype wire

// ----- dv/bole_result_checker.sv -----
// Result checker for the bounded ordered list engine: list predictor and comparison.

// Watches both stream sides of the engine. Every accepted command item is run
// through a local copy of the list, and the expected result is queued. Every
// accepted result item is compared, field by field, against the oldest one.
module bole_result_checker
  import bole_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic                  cmd_ready_i,
  input  logic [LIST_IN_W-1:0]  cmd_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [LIST_OUT_W-1:0] res_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    list_size_o
);

  typedef struct packed {
    logic [LIST_CNT_OUT_W-1:0] count;
    logic [LIST_VAL_W-1:0]     front;
    logic [LIST_VAL_W-1:0]     back;
    logic [LIST_VAL_W-1:0]     read;
    status_e                   status;
  } list_result_t;

  // Local copy of the list, front at index 0.
  logic [LIST_VAL_W-1:0] contents[$];
  // Results still owed by the engine, oldest first.
  list_result_t          owed_results[$];
  list_result_t          oldest;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    list_size_o  = 0;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Applies one command to the local list and returns the result it should give.
  function automatic list_result_t apply_command(input cmd_e op,
                                                 input logic [LIST_POS_W-1:0] pos,
                                                 input logic [LIST_VAL_W-1:0] val);
    list_result_t r;
    int           n;
    int           at;
    bit           full;
    r        = '0;
    r.status = ST_OK;
    n        = contents.size();
    at       = int'(pos);
    full     = (n >= LIST_CAPACITY);
    case (op)
      CMD_APPEND: begin
        if (full) r.status = ST_FULL;
        else contents.insert(n, val);
      end
      CMD_PREPEND: begin
        if (full) r.status = ST_FULL;
        else contents.insert(0, val);
      end
      CMD_TAKE_FIRST: begin
        if (n == 0) r.status = ST_EMPTY;
        else contents.delete(0);
      end
      CMD_TAKE_LAST: begin
        if (n == 0) r.status = ST_EMPTY;
        else contents.delete(n - 1);
      end
      CMD_INSERT: begin
        // A position past the end is rejected before fullness is considered.
        if (at > n) r.status = ST_BADPOS;
        else if (full) r.status = ST_FULL;
        else contents.insert(at, val);
      end
      CMD_ERASE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (at >= n) r.status = ST_BADPOS;
        else contents.delete(at);
      end
      CMD_READ: begin
        if (at >= n) r.status = ST_BADPOS;
        else r.read = contents[at];
      end
      default: begin
        // The unused command code changes nothing and reports success.
      end
    endcase
    n       = contents.size();
    r.count = n[LIST_CNT_OUT_W-1:0];
    if (n > 0) begin
      r.front = contents[0];
      r.back  = contents[n-1];
    end
    return r;
  endfunction

  // Prediction on command acceptance, comparison on result acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contents.delete();
      owed_results.delete();
    end else begin
      if (cmd_valid_i && cmd_ready_i) begin
        owed_results.insert(owed_results.size(),
                            apply_command(cmd_e'(cmd_data_i[2:0]), cmd_data_i[7:3],
                                          cmd_data_i[39:8]));
      end
      if (res_valid_i && res_ready_i) begin
        if (owed_results.size() == 0) begin
          report($sformatf("result item with none expected: %h", res_data_i));
        end else begin
          oldest = owed_results[0];
          owed_results.delete(0);
          if (res_data_i[4:0] !== oldest.count)
            report($sformatf("count got %0d expected %0d", res_data_i[4:0], oldest.count));
          if (res_data_i[36:5] !== oldest.front)
            report($sformatf("front_value got %h expected %h", res_data_i[36:5],
                             oldest.front));
          if (res_data_i[68:37] !== oldest.back)
            report($sformatf("back_value got %h expected %h", res_data_i[68:37],
                             oldest.back));
          if (res_data_i[100:69] !== oldest.read)
            report($sformatf("read_value got %h expected %h", res_data_i[100:69],
                             oldest.read));
          if (res_data_i[102:101] !== oldest.status)
            report($sformatf("status got %0d expected %0d", res_data_i[102:101],
                             oldest.status));
        end
      end
    end
    pending_o   = owed_results.size();
    list_size_o = contents.size();
  end

endmodule

// ----- dv/bounded_ordered_list_engine_tb.sv -----
// Testbench top for the bounded ordered list engine: clock, reset, stimulus and verdict.

module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  // Command code outside the defined set; the engine must treat it as a no-op.
  localparam cmd_e CMD_UNUSED  = cmd_e'(3'd7);
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   PHASES      = 10;
  localparam int   PHASE_ITEMS = 100;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [LIST_IN_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [LIST_OUT_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int list_size;
  int cycles  = 0;
  int rx_mode = 0;
  int rx_tick = 0;

  // Share of growing commands in each random phase.
  int grow_pct[PHASES] = '{75, 75, 20, 50, 75, 10, 50, 75, 30, 50};

  bounded_ordered_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bole_result_checker results_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_size_o  (list_size)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side stalls: always ready, coin flip, or ready one cycle in four.
  always @(negedge clk_i) begin
    if (rx_tick == 0) begin
      rx_mode <= $urandom_range(2);
      rx_tick <= $urandom_range(80, 20);
    end else begin
      rx_tick <= rx_tick - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(1));
      default: m_axis_tready <= (rx_tick[1:0] == 2'd0);
    endcase
  end

  // Drives one command item; entered and left at a falling edge.
  task automatic send_item(input cmd_e op, input logic [LIST_POS_W-1:0] pos,
                           input logic [LIST_VAL_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Builds one random command from the current list size and sends it.
  task automatic send_random(input int grow);
    int                    k;
    cmd_e                  op;
    logic [LIST_POS_W-1:0] pos;
    logic [LIST_VAL_W-1:0] val;
    k = $urandom_range(99);
    if (k < grow) begin
      case ($urandom_range(2))
        0:       op = CMD_APPEND;
        1:       op = CMD_PREPEND;
        default: op = CMD_INSERT;
      endcase
    end else if (k < grow + 20) begin
      op = CMD_READ;
    end else if (k < grow + 23) begin
      op = CMD_UNUSED;
    end else begin
      case ($urandom_range(2))
        0:       op = CMD_TAKE_FIRST;
        1:       op = CMD_TAKE_LAST;
        default: op = CMD_ERASE;
      endcase
    end
    // Mostly positions within the list or at its end, some anywhere.
    if ($urandom_range(9) == 0) pos = LIST_POS_W'($urandom_range(31));
    else pos = LIST_POS_W'($urandom_range(list_size));
    case ($urandom_range(15))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    send_item(op, pos, val);
  endtask

  // Stops sending and waits until every owed result has been taken.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // One random phase, sent in bursts with idle gaps unless told otherwise.
  task automatic run_phase(input int grow, input bit no_gaps);
    int left;
    int burst;
    int gap;
    left = PHASE_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(16, 1);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_random(grow);
        left--;
      end
      gap = no_gaps ? 0 : $urandom_range(4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-list cases first.
    send_item(CMD_TAKE_FIRST, 5'd0, 32'h0);
    send_item(CMD_TAKE_LAST, 5'd0, 32'h0);
    send_item(CMD_ERASE, 5'd0, 32'h0);
    send_item(CMD_READ, 5'd0, 32'h0);
    send_item(CMD_INSERT, 5'd1, 32'h1111_1111);
    send_item(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, 5'd0, 32'h0000_0000);
    send_item(CMD_PREPEND, 5'd0, 32'h1234_5678);
    // Insert at the end must move the back.
    send_item(CMD_INSERT, 5'd3, 32'hA5A5_A5A5);
    send_item(CMD_INSERT, 5'd2, 32'h5A5A_5A5A);
    send_item(CMD_READ, 5'd0, 32'h0);
    send_item(CMD_READ, 5'd4, 32'h0);
    send_item(CMD_READ, 5'd5, 32'h0);
    send_item(CMD_READ, 5'd31, 32'h0);
    send_item(CMD_ERASE, 5'd5, 32'h0);
    send_item(CMD_ERASE, 5'd31, 32'h0);
    send_item(CMD_INSERT, 5'd31, 32'hDEAD_BEEF);
    send_item(CMD_ERASE, 5'd2, 32'h0);
    send_item(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_item(CMD_TAKE_FIRST, 5'd0, 32'h0);
    send_item(CMD_TAKE_LAST, 5'd0, 32'h0);
    send_item(CMD_ERASE, 5'd0, 32'h0);
    send_item(CMD_READ, 5'd0, 32'h0);
    drain();

    // Random phases; the list is allowed to settle between them.
    for (int p = 0; p < PHASES; p++) begin
      run_phase(grow_pct[p], (p == 3) || (p == 7));
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
